>>> rtl/core/llhb_pkg.sv
// Package for the last-lines history buffer.
// Holds the request operation codes, the newline byte value and the lines-kept reset value.
// No dependencies.
`default_nettype none

package llhb_pkg;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_END  = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	localparam logic [7:0] NEWLINE_BYTE  = 8'd10;
	localparam logic [4:0] LINES_KEPT_RST = 5'd10;

endpackage

`default_nettype wire

>>> rtl/core/llhb_if.sv
// Valid/ready channel interfaces for the last-lines history buffer.
// llhb_req_if carries requests, llhb_rsp_if carries results.
// No dependencies.
`default_nettype none

interface llhb_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] char_in;

	modport source (output valid, output operation, output char_in, input ready);
	modport sink   (input valid, input operation, input char_in, output ready);
endinterface

interface llhb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic       line_end;
	logic       done_res;

	modport source (output valid, output char_out, output line_end, output done_res,
		input ready);
	modport sink   (input valid, input char_out, input line_end, input done_res,
		output ready);
endinterface

`default_nettype wire

>>> rtl/core/last_lines_history_buffer_core.sv
// Takes push, end and read requests over the request channel where the core allows.
// Pushes may follow every cycle while no read is in flight and no result waits to be
// taken. On a read request, the line store and the length table are read into
// registers when the read is accepted; the result is then built from them in the
// output registers and holds until taken. Reset clears the control state but loads
// lines_kept_q with LINES_KEPT_RST; the two memories are not cleared and need no sweep.
// Depends on llhb_pkg and the channel interfaces in llhb_if.sv.
`default_nettype none

module last_lines_history_buffer_core
	import llhb_pkg::*;
#(
	parameter int MAX_LINES  = 16,
	parameter int LINE_LIMIT = 100
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	llhb_req_if.sink        req,
	llhb_rsp_if.source      rsp,
	input  wire logic       cfg_we,
	input  wire logic [4:0] cfg_wdata
);

	localparam int SW          = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
	localparam int CW          = $clog2(MAX_LINES + 1);
	localparam int LW          = $clog2(LINE_LIMIT);
	localparam int AW          = SW + LW;
	localparam int STORE_DEPTH = MAX_LINES * (2 ** LW);

	logic [7:0]    line_store [0:STORE_DEPTH-1];
	logic [LW-1:0] slot_length [0:MAX_LINES-1];

	logic [4:0]    lines_kept_q;
	logic [SW-1:0] write_slot_q;
	logic [CW-1:0] lines_held_q;
	logic [LW-1:0] open_length_q;
	logic          input_ended_q;
	logic [CW-1:0] read_line_q;
	logic [LW-1:0] read_column_q;

	logic          rd_s1;
	logic          rd_done_s1;
	logic [7:0]    store_rd_q;
	logic [LW-1:0] len_rd_q;

	logic          rsp_valid_q;
	logic [7:0]    char_out_q;
	logic          line_end_q;
	logic          done_res_q;

	logic          req_fire;
	op_t           op;
	logic [CW-1:0] eff_count;
	logic [CW-1:0] held_eff;
	logic [CW-1:0] held_next;
	logic [SW-1:0] slot_next;
	logic [SW+1:0] slot_sum;
	logic [SW-1:0] rd_slot;
	logic [LW-1:0] new_len;
	logic          do_push;
	logic          do_end;
	logic          do_read;
	logic          close_line;
	logic [LW-1:0] close_len;
	logic [LW:0]   col_inc;
	logic          len_bad;
	logic          col_last;

	assign req.ready = !rd_s1 && (!rsp_valid_q || rsp.ready);
	assign req_fire  = req.valid && req.ready;
	assign op        = op_t'(req.operation);

	assign rsp.valid    = rsp_valid_q;
	assign rsp.char_out = char_out_q;
	assign rsp.line_end = line_end_q;
	assign rsp.done_res = done_res_q;

	always_comb begin
		if (lines_kept_q == 5'd0) begin
			eff_count = CW'(1);
		end else if (32'(lines_kept_q) > MAX_LINES) begin
			eff_count = CW'(MAX_LINES);
		end else begin
			eff_count = CW'(lines_kept_q);
		end
	end

	assign held_eff  = (lines_held_q > eff_count) ? eff_count : lines_held_q;
	assign held_next = (held_eff < eff_count) ? held_eff + CW'(1) : held_eff;
	assign slot_next = (32'(write_slot_q) + 1 >= MAX_LINES) ? '0 : write_slot_q + SW'(1);

	assign slot_sum = (SW+2)'(write_slot_q) + (SW+2)'(MAX_LINES) - (SW+2)'(held_eff)
		+ (SW+2)'(read_line_q);
	assign rd_slot  = (slot_sum >= (SW+2)'(MAX_LINES)) ? SW'(slot_sum - (SW+2)'(MAX_LINES))
		: SW'(slot_sum);

	assign new_len = open_length_q + LW'(1);
	assign do_push = req_fire && (op == OP_PUSH) && !input_ended_q;
	assign do_end  = req_fire && (op == OP_END) && !input_ended_q;
	assign do_read = req_fire && (op == OP_READ);

	always_comb begin
		close_line = 1'b0;
		close_len  = new_len;
		if (do_push) begin
			close_line = (req.char_in == NEWLINE_BYTE) || (32'(new_len) >= LINE_LIMIT - 1);
		end else if (do_end) begin
			close_line = (open_length_q != '0);
			close_len  = open_length_q;
		end
	end

	assign col_inc  = {1'b0, read_column_q} + (LW+1)'(1);
	assign len_bad  = (len_rd_q == '0) || (read_column_q >= len_rd_q);
	assign col_last = (col_inc >= {1'b0, len_rd_q});

	always_ff @(posedge clk) begin
		if (do_push) begin
			line_store[{write_slot_q, open_length_q}] <= req.char_in;
		end
		if (do_read) begin
			store_rd_q <= line_store[AW'({rd_slot, read_column_q})];
		end
	end

	always_ff @(posedge clk) begin
		if (close_line) begin
			slot_length[write_slot_q] <= close_len;
		end
		if (do_read) begin
			len_rd_q <= slot_length[rd_slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_kept_q  <= LINES_KEPT_RST;
			write_slot_q  <= '0;
			lines_held_q  <= '0;
			open_length_q <= '0;
			input_ended_q <= 1'b0;
			read_line_q   <= '0;
			read_column_q <= '0;
			rd_s1         <= 1'b0;
			rd_done_s1    <= 1'b0;
			rsp_valid_q   <= 1'b0;
			char_out_q    <= '0;
			line_end_q    <= 1'b0;
			done_res_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				lines_kept_q <= cfg_wdata;
			end

			if (do_push) begin
				open_length_q <= new_len;
			end
			if (close_line) begin
				open_length_q <= '0;
				write_slot_q  <= slot_next;
				lines_held_q  <= held_next;
			end
			if (do_end) begin
				input_ended_q <= 1'b1;
				read_line_q   <= '0;
				read_column_q <= '0;
			end

			rd_s1 <= do_read;
			if (do_read) begin
				rd_done_s1 <= !input_ended_q || (read_line_q >= held_eff);
			end

			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			if (rd_s1) begin
				rsp_valid_q <= 1'b1;
				char_out_q  <= '0;
				line_end_q  <= 1'b0;
				done_res_q  <= 1'b1;
				if (!rd_done_s1) begin
					if (len_bad) begin
						read_line_q   <= read_line_q + CW'(1);
						read_column_q <= '0;
					end else begin
						char_out_q <= store_rd_q;
						done_res_q <= 1'b0;
						if (col_last) begin
							line_end_q    <= 1'b1;
							read_line_q   <= read_line_q + CW'(1);
							read_column_q <= '0;
						end else begin
							read_column_q <= LW'(col_inc);
						end
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/llhb_checker.sv
// Port-level checker for the last-lines history buffer core.
// Bound to last_lines_history_buffer_core; depends on llhb_pkg.
`default_nettype none

module llhb_checker
	import llhb_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_ready,
	input wire logic [1:0] req_operation,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic [7:0] rsp_char_out,
	input wire logic       rsp_line_end,
	input wire logic       rsp_done_res
);

	logic read_fire;

	assign read_fire = req_valid && req_ready && (req_operation == OP_READ);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_out)
			&& $stable(rsp_line_end) && $stable(rsp_done_res))
		else $error("Result changed while stalled.");

	a_rsp_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(read_fire, 2))
		else $error("Result without a matching read request.");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_done_res |-> (rsp_char_out == 8'd0) && !rsp_line_end)
		else $error("Done result carries a byte or a line end.");

	a_read_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		read_fire |=> !req_ready)
		else $error("Request accepted while a read is in flight.");

endmodule

bind last_lines_history_buffer_core llhb_checker u_llhb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_operation (req.operation),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_char_out  (rsp.char_out),
	.rsp_line_end  (rsp.line_end),
	.rsp_done_res  (rsp.done_res)
);

`default_nettype wire
